### sv/ifcu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifcu_pkg
// shared types and constants of the float classify / unpack pipeline
// ----------------------------------------------------------------------------
package ifcu_pkg;

    localparam int CMD_W   = 2;
    localparam int VALUE_W = 64;
    localparam int FRAC_W  = 52;
    localparam int BEXP_W  = 11;
    localparam int TEXP_W  = 12;
    localparam int SIG_W   = 54;
    localparam int SIGW_W  = 6;
    localparam int EXPW_W  = 4;

    // format codes of the command field
    localparam logic [CMD_W-1:0] FMT_HALF   = 2'd0;
    localparam logic [CMD_W-1:0] FMT_SINGLE = 2'd1;
    localparam logic [CMD_W-1:0] FMT_DOUBLE = 2'd2;

    // fields after the split stage
    typedef struct packed {
        logic [CMD_W-1:0]  fmt;
        logic              neg;
        logic [BEXP_W-1:0] bexp;
        logic [FRAC_W-1:0] frac;
        logic [SIGW_W-1:0] sig_width;
        logic [EXPW_W-1:0] exp_width;
    } split_t;

    // class flags decided in the classify stage
    typedef struct packed {
        logic zero;
        logic inf;
        logic nan;
        logic qnan;
        logic indef;
        logic sub;
        logic normal;
    } flags_t;

    typedef struct packed {
        split_t            fld;
        flags_t            flags;
        logic [TEXP_W-1:0] bias;
    } class_t;

    typedef struct packed {
        logic [SIG_W-1:0]         significand;
        logic [BEXP_W-1:0]        biased_exponent;
        logic signed [TEXP_W-1:0] true_exponent;
        logic [SIGW_W-1:0]        significand_width;
        logic [EXPW_W-1:0]        exponent_width;
        logic                     negative;
        logic                     is_zero;
        logic                     infinity;
        logic                     is_nan;
        logic                     is_quiet_nan;
        logic                     indef_nan;
        logic                     denormal;
    } result_t;

endpackage

### sv/ifcu_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifcu_split
// first stage: format decode and sign / exponent / fraction extraction
// ----------------------------------------------------------------------------
module ifcu_split (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ifcu_pkg::CMD_W-1:0]    in_command,
    input  logic [ifcu_pkg::VALUE_W-1:0]  in_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ifcu_pkg::split_t              out_data
);

    logic             valid_reg;
    ifcu_pkg::split_t data_reg;
    ifcu_pkg::split_t data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        case (in_command)
            ifcu_pkg::FMT_HALF: begin
                data_next.fmt       = ifcu_pkg::FMT_HALF;
                data_next.neg       = in_value[15];
                data_next.bexp      = {6'd0, in_value[14:10]};
                data_next.frac      = {42'd0, in_value[9:0]};
                data_next.sig_width = 6'd11;
                data_next.exp_width = 4'd5;
            end
            ifcu_pkg::FMT_SINGLE: begin
                data_next.fmt       = ifcu_pkg::FMT_SINGLE;
                data_next.neg       = in_value[31];
                data_next.bexp      = {3'd0, in_value[30:23]};
                data_next.frac      = {29'd0, in_value[22:0]};
                data_next.sig_width = 6'd24;
                data_next.exp_width = 4'd8;
            end
            default: begin
                // unused code falls back to double
                data_next.fmt       = ifcu_pkg::FMT_DOUBLE;
                data_next.neg       = in_value[63];
                data_next.bexp      = in_value[62:52];
                data_next.frac      = in_value[51:0];
                data_next.sig_width = 6'd53;
                data_next.exp_width = 4'd11;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### sv/ifcu_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifcu_classify
// second stage: exponent / fraction tests and class flags
// ----------------------------------------------------------------------------
module ifcu_classify (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  ifcu_pkg::split_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ifcu_pkg::class_t  out_data
);

    logic             valid_reg;
    ifcu_pkg::class_t data_reg;
    ifcu_pkg::class_t data_next;

    logic exp_zero;
    logic exp_ones;
    logic frac_zero;
    logic qbit;
    logic low_zero;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        case (in_data.fmt)
            ifcu_pkg::FMT_HALF: begin
                exp_ones       = (in_data.bexp == 11'h01f);
                qbit           = in_data.frac[9];
                low_zero       = (in_data.frac[8:0] == '0);
                data_next.bias = 12'd15;
            end
            ifcu_pkg::FMT_SINGLE: begin
                exp_ones       = (in_data.bexp == 11'h0ff);
                qbit           = in_data.frac[22];
                low_zero       = (in_data.frac[21:0] == '0);
                data_next.bias = 12'd127;
            end
            default: begin
                exp_ones       = (in_data.bexp == 11'h7ff);
                qbit           = in_data.frac[51];
                low_zero       = (in_data.frac[50:0] == '0);
                data_next.bias = 12'd1023;
            end
        endcase

        exp_zero  = (in_data.bexp == '0);
        frac_zero = (in_data.frac == '0);

        data_next.fld          = in_data;
        data_next.flags.zero   = exp_zero && frac_zero;
        data_next.flags.inf    = exp_ones && frac_zero;
        data_next.flags.nan    = exp_ones && !frac_zero;
        data_next.flags.qnan   = exp_ones && !frac_zero && qbit;
        data_next.flags.indef  = exp_ones && qbit && in_data.neg && low_zero;
        data_next.flags.sub    = exp_zero && !frac_zero;
        data_next.flags.normal = !exp_zero && !exp_ones;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### sv/ifcu_assemble.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifcu_assemble
// third stage: hidden bit, unbiased exponent and the output register
// ----------------------------------------------------------------------------
module ifcu_assemble (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  ifcu_pkg::class_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ifcu_pkg::result_t out_data
);

    logic                              valid_reg;
    ifcu_pkg::result_t                 data_reg;
    ifcu_pkg::result_t                 data_next;
    logic [ifcu_pkg::SIG_W-1:0]        hidden;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        case (in_data.fld.fmt)
            ifcu_pkg::FMT_HALF:   hidden = ifcu_pkg::SIG_W'(1) << 10;
            ifcu_pkg::FMT_SINGLE: hidden = ifcu_pkg::SIG_W'(1) << 23;
            default:              hidden = ifcu_pkg::SIG_W'(1) << 52;
        endcase

        data_next.significand = {2'b00, in_data.fld.frac}
                              | (in_data.flags.normal ? hidden : '0);
        data_next.biased_exponent = in_data.fld.bexp;
        // subnormals share the minimum exponent of the normals
        data_next.true_exponent = $signed({1'b0, in_data.fld.bexp}
                                          - in_data.bias
                                          + {11'd0, in_data.flags.sub});
        data_next.significand_width = in_data.fld.sig_width;
        data_next.exponent_width    = in_data.fld.exp_width;
        data_next.negative          = in_data.fld.neg;
        data_next.is_zero           = in_data.flags.zero;
        data_next.infinity          = in_data.flags.inf;
        data_next.is_nan            = in_data.flags.nan;
        data_next.is_quiet_nan      = in_data.flags.qnan;
        data_next.indef_nan         = in_data.flags.indef;
        data_next.denormal          = in_data.flags.sub;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### sv/ieee_float_classify_unpack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ieee_float_classify_unpack
// classifies and unpacks a half, single or double bit pattern
// ----------------------------------------------------------------------------
// usage
//   input channel s_*: s_command picks the format (half, single, double; the
//   unused code is taken as double), s_value carries the raw pattern
//   right-aligned. one transaction in gives exactly one transaction out.
//   result channel m_*: significand with hidden bit for normals, stored and
//   unbiased exponent, format widths and the class flags.
// stages and throughput
//   three register stages (split, classify, assemble). one transaction per
//   cycle is sustained while m_ready is high; the exponent subtract and the
//   wide fraction compares each sit in a stage of their own.
// reset
//   aresetn clears the stage valid bits only; the pipeline comes up empty.
// stall
//   when m_ready is low the last stage holds its result and each stage ahead
//   keeps taking transactions until it fills, then s_ready falls. nothing is
//   dropped or repeated; ready travels back through one gate per stage.
// ----------------------------------------------------------------------------
module ieee_float_classify_unpack (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [ifcu_pkg::CMD_W-1:0]           s_command,
    input  logic [ifcu_pkg::VALUE_W-1:0]         s_value,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [ifcu_pkg::SIG_W-1:0]           m_significand,
    output logic [ifcu_pkg::BEXP_W-1:0]          m_biased_exponent,
    output logic signed [ifcu_pkg::TEXP_W-1:0]   m_true_exponent,
    output logic [ifcu_pkg::SIGW_W-1:0]          m_significand_width,
    output logic [ifcu_pkg::EXPW_W-1:0]          m_exponent_width,
    output logic                                 m_negative,
    output logic                                 m_is_zero,
    output logic                                 m_infinity,
    output logic                                 m_is_nan,
    output logic                                 m_is_quiet_nan,
    output logic                                 m_indef_nan,
    output logic                                 m_denormal
);

    // stage 1 -> stage 2
    logic              split_valid;
    logic              split_ready;
    ifcu_pkg::split_t  split_data;

    // stage 2 -> stage 3
    logic              class_valid;
    logic              class_ready;
    ifcu_pkg::class_t  class_data;

    // stage 3 output register
    ifcu_pkg::result_t result;

    // field extraction per format
    ifcu_split u_split (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_command (s_command),
        .in_value   (s_value),
        .out_valid  (split_valid),
        .out_ready  (split_ready),
        .out_data   (split_data)
    );

    // zero / all-ones tests and class flags
    ifcu_classify u_classify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (split_valid),
        .in_ready  (split_ready),
        .in_data   (split_data),
        .out_valid (class_valid),
        .out_ready (class_ready),
        .out_data  (class_data)
    );

    // hidden bit, unbiased exponent, output register
    ifcu_assemble u_assemble (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (class_valid),
        .in_ready  (class_ready),
        .in_data   (class_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (result)
    );

    // unpack the result struct onto the ports
    assign m_significand       = result.significand;
    assign m_biased_exponent   = result.biased_exponent;
    assign m_true_exponent     = result.true_exponent;
    assign m_significand_width = result.significand_width;
    assign m_exponent_width    = result.exponent_width;
    assign m_negative          = result.negative;
    assign m_is_zero           = result.is_zero;
    assign m_infinity          = result.infinity;
    assign m_is_nan            = result.is_nan;
    assign m_is_quiet_nan      = result.is_quiet_nan;
    assign m_indef_nan         = result.indef_nan;
    assign m_denormal          = result.denormal;

endmodule

### sv/ifcu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifcu_checker
// port-level checks of the classify / unpack block, bound to the top level
// ----------------------------------------------------------------------------
module ifcu_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [ifcu_pkg::SIG_W-1:0]         m_significand,
    input logic                               m_negative,
    input logic                               m_is_zero,
    input logic                               m_infinity,
    input logic                               m_is_nan,
    input logic                               m_is_quiet_nan,
    input logic                               m_indef_nan,
    input logic                               m_denormal
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // a free output leaves the whole pipeline free
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input blocked while output is ready");

    // the main classes exclude one another
    a_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0({m_is_zero, m_infinity, m_is_nan, m_denormal}))
        else $error("more than one class flag set");

    // indefinite implies negative quiet nan
    a_indef: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_indef_nan |-> m_is_quiet_nan && m_is_nan && m_negative)
        else $error("indefinite nan without quiet negative nan");

    // zero carries an empty significand
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_zero |-> m_significand == '0)
        else $error("zero with nonzero significand");

endmodule

bind ieee_float_classify_unpack ifcu_checker u_ifcu_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_significand  (m_significand),
    .m_negative     (m_negative),
    .m_is_zero      (m_is_zero),
    .m_infinity     (m_infinity),
    .m_is_nan       (m_is_nan),
    .m_is_quiet_nan (m_is_quiet_nan),
    .m_indef_nan    (m_indef_nan),
    .m_denormal     (m_denormal)
);
